@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands for the ChaCha20 block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NOW(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("assertion failed");

`endif

@@ sv/cc20_pkg.sv @@
// ---------------------------------------------------------------------------
// cc20_pkg
// Types, widths and constants shared by the ChaCha20 keystream block.
// ---------------------------------------------------------------------------
package cc20_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 16;
  localparam int NUM_LANES  = 4;
  localparam int PAIR_W     = 2 * WORD_W;
  localparam int NUM_PAIRS  = NUM_WORDS / 2;
  localparam int PAIR_IDX_W = 3;
  localparam int CTR_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int DEFAULT_NUM_ROUNDS = 20;

  // The "expand 32-byte k" constant, little-endian words.
  localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

  // Rotation amounts of the two halves of a quarter round.
  localparam int ROT_D_FIRST  = 16;
  localparam int ROT_B_FIRST  = 12;
  localparam int ROT_D_SECOND = 8;
  localparam int ROT_B_SECOND = 7;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_WORDS-1:0] state_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_01   = 3'd0,
    CFG_KEY_23   = 3'd1,
    CFG_KEY_45   = 3'd2,
    CFG_KEY_67   = 3'd3,
    CFG_NONCE_0  = 3'd4,
    CFG_NONCE_12 = 3'd5
  } cfg_idx_t;

  // Rotate left by a constant amount.
  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage

@@ sv/cc20_in_if.sv @@
// ---------------------------------------------------------------------------
// cc20_in_if
// Input channel: one block counter per transaction, valid/ready handshake.
// ---------------------------------------------------------------------------
interface cc20_in_if import cc20_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CTR_W-1:0] block_counter;

  modport source (output valid, output block_counter, input ready);
  modport sink   (input valid, input block_counter, output ready);
endinterface

@@ sv/cc20_out_if.sv @@
// ---------------------------------------------------------------------------
// cc20_out_if
// Result channel: one keystream word pair per transaction, valid/ready.
// ---------------------------------------------------------------------------
interface cc20_out_if import cc20_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PAIR_W-1:0]     keystream_pair;
  logic [PAIR_IDX_W-1:0] pair_index;
  logic                  last_pair;

  modport source (output valid, output keystream_pair, output pair_index,
                  output last_pair, input ready);
  modport sink   (input valid, input keystream_pair, input pair_index,
                  input last_pair, output ready);
endinterface

@@ sv/cc20_qr_half.sv @@
// ---------------------------------------------------------------------------
// cc20_qr_half
// One half of a ChaCha quarter round: two add-xor-rotate steps per cycle.
// ---------------------------------------------------------------------------
module cc20_qr_half import cc20_pkg::*; (
  input  logic  second_half,
  input  word_t a_in,
  input  word_t b_in,
  input  word_t c_in,
  input  word_t d_in,
  output word_t a_out,
  output word_t b_out,
  output word_t c_out,
  output word_t d_out
);

  word_t a_sum;
  word_t d_mix;
  word_t d_rot;
  word_t c_sum;
  word_t b_mix;
  word_t b_rot;

  // The first half rotates by 16 and 12, the second by 8 and 7.
  always_comb begin
    a_sum = a_in + b_in;
    d_mix = d_in ^ a_sum;
    d_rot = second_half ? rotl(d_mix, ROT_D_SECOND) : rotl(d_mix, ROT_D_FIRST);
    c_sum = c_in + d_rot;
    b_mix = b_in ^ c_sum;
    b_rot = second_half ? rotl(b_mix, ROT_B_SECOND) : rotl(b_mix, ROT_B_FIRST);
  end

  assign a_out = a_sum;
  assign b_out = b_rot;
  assign c_out = c_sum;
  assign d_out = d_rot;

endmodule

@@ sv/cc20_cfg.sv @@
// ---------------------------------------------------------------------------
// cc20_cfg
// Key and nonce registers; assembles the 16-word initial state.
// ---------------------------------------------------------------------------
module cc20_cfg import cc20_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  word_t                 block_counter,
  output state_t                init_words
);

  logic [PAIR_W-1:0] key01_r;
  logic [PAIR_W-1:0] key23_r;
  logic [PAIR_W-1:0] key45_r;
  logic [PAIR_W-1:0] key67_r;
  word_t             nonce0_r;
  logic [PAIR_W-1:0] nonce12_r;

  // Register writes; indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r   <= '0;
      key23_r   <= '0;
      key45_r   <= '0;
      key67_r   <= '0;
      nonce0_r  <= '0;
      nonce12_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_KEY_01:   key01_r   <= cfg_wdata[PAIR_W-1:0];
        CFG_KEY_23:   key23_r   <= cfg_wdata[PAIR_W-1:0];
        CFG_KEY_45:   key45_r   <= cfg_wdata[PAIR_W-1:0];
        CFG_KEY_67:   key67_r   <= cfg_wdata[PAIR_W-1:0];
        CFG_NONCE_0:  nonce0_r  <= cfg_wdata[WORD_W-1:0];
        CFG_NONCE_12: nonce12_r <= cfg_wdata[PAIR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Constant, key, counter and nonce in the IETF word layout.
  always_comb begin
    init_words[0]  = SIGMA_0;
    init_words[1]  = SIGMA_1;
    init_words[2]  = SIGMA_2;
    init_words[3]  = SIGMA_3;
    init_words[4]  = key01_r[WORD_W-1:0];
    init_words[5]  = key01_r[PAIR_W-1:WORD_W];
    init_words[6]  = key23_r[WORD_W-1:0];
    init_words[7]  = key23_r[PAIR_W-1:WORD_W];
    init_words[8]  = key45_r[WORD_W-1:0];
    init_words[9]  = key45_r[PAIR_W-1:WORD_W];
    init_words[10] = key67_r[WORD_W-1:0];
    init_words[11] = key67_r[PAIR_W-1:WORD_W];
    init_words[12] = block_counter;
    init_words[13] = nonce0_r;
    init_words[14] = nonce12_r[WORD_W-1:0];
    init_words[15] = nonce12_r[PAIR_W-1:WORD_W];
  end

endmodule

@@ sv/chacha20_ietf_block_top.sv @@
// ---------------------------------------------------------------------------
// chacha20_ietf_block_top
// ChaCha20 block function (IETF layout) with an iterative round datapath.
// ---------------------------------------------------------------------------
// Usage:
//   Load the key and nonce through the cfg_ write port while the block is
//   idle. Each transaction on in_ch carries a 32-bit block counter; the block
//   answers with eight transactions on out_ch, pair 0 first, each holding two
//   keystream words (lower word in the low half); the eighth has last_pair set.
//   Four half-quarter-round lanes run one column or diagonal half step per
//   cycle in the S_ROUND state. The S_FINAL state then adds the initial state.
//   in_ch.ready is high only while the block is idle. The output register lets
//   the next block start while the last pair still waits to be taken.
//   A stalled receiver holds the current pair and pauses emission.
//   Reset (synchronous, active low) clears key and nonce to zero, returns the
//   sequencer to idle and drops out_ch.valid.
// ---------------------------------------------------------------------------
module chacha20_ietf_block_top import cc20_pkg::*; #(
  parameter int NUM_ROUNDS = DEFAULT_NUM_ROUNDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cc20_in_if.sink               in_ch,
  cc20_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Rounds are done in column/diagonal pairs, four half steps per pair.
  localparam int NUM_STEPS = (NUM_ROUNDS / 2) * 4;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_FINAL,
    S_EMIT
  } state_e_t;

  state_e_t              state_r;
  logic [STEP_W-1:0]     step_r;
  logic [PAIR_IDX_W-1:0] emit_r;
  word_t                 counter_r;
  state_t                work_r;
  logic                  out_valid_r;
  logic [PAIR_W-1:0]     out_pair_r;
  logic [PAIR_IDX_W-1:0] out_idx_r;
  logic                  out_last_r;

  word_t  cfg_counter;
  state_t init_words;
  state_t round_nxt;
  logic   diag;
  logic   second_half;
  logic   emit_fire;
  word_t  lane_a [NUM_LANES];
  word_t  lane_b [NUM_LANES];
  word_t  lane_c [NUM_LANES];
  word_t  lane_d [NUM_LANES];
  word_t  res_a  [NUM_LANES];
  word_t  res_b  [NUM_LANES];
  word_t  res_c  [NUM_LANES];
  word_t  res_d  [NUM_LANES];

  // The counter comes straight from the input at accept, then from its copy.
  assign cfg_counter = (state_r == S_IDLE) ? in_ch.block_counter : counter_r;

  cc20_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .block_counter (cfg_counter),
    .init_words    (init_words)
  );

  // Step bit 0 picks the quarter-round half, bit 1 the diagonal round.
  assign second_half = step_r[0];
  assign diag        = step_r[1];

  // A pair is issued when the output register is empty or being taken.
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // Route state words to the lanes for a column or a diagonal round.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_a[i] = work_r[i];
      if (diag) begin
        lane_b[i] = work_r[NUM_LANES + ((i + 1) % NUM_LANES)];
        lane_c[i] = work_r[2 * NUM_LANES + ((i + 2) % NUM_LANES)];
        lane_d[i] = work_r[3 * NUM_LANES + ((i + 3) % NUM_LANES)];
      end else begin
        lane_b[i] = work_r[NUM_LANES + i];
        lane_c[i] = work_r[2 * NUM_LANES + i];
        lane_d[i] = work_r[3 * NUM_LANES + i];
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    cc20_qr_half u_qr (
      .second_half (second_half),
      .a_in        (lane_a[l]),
      .b_in        (lane_b[l]),
      .c_in        (lane_c[l]),
      .d_in        (lane_d[l]),
      .a_out       (res_a[l]),
      .b_out       (res_b[l]),
      .c_out       (res_c[l]),
      .d_out       (res_d[l])
    );
  end

  // Put the lane results back where their operands came from.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      round_nxt[i] = res_a[i];
      if (diag) begin
        round_nxt[NUM_LANES + ((i + 1) % NUM_LANES)]     = res_b[i];
        round_nxt[2 * NUM_LANES + ((i + 2) % NUM_LANES)] = res_c[i];
        round_nxt[3 * NUM_LANES + ((i + 3) % NUM_LANES)] = res_d[i];
      end else begin
        round_nxt[NUM_LANES + i]     = res_b[i];
        round_nxt[2 * NUM_LANES + i] = res_c[i];
        round_nxt[3 * NUM_LANES + i] = res_d[i];
      end
    end
  end

  // Sequencer, working state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            counter_r <= in_ch.block_counter;
            work_r    <= init_words;
            step_r    <= '0;
            state_r   <= S_ROUND;
          end
        end
        S_ROUND: begin
          work_r <= round_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(NUM_STEPS - 1)) begin
            state_r <= S_FINAL;
          end
        end
        S_FINAL: begin
          for (int i = 0; i < NUM_WORDS; i++) begin
            work_r[i] <= work_r[i] + init_words[i];
          end
          emit_r  <= '0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          // Words 0 and 1 go out, the rest shift down by one pair.
          if (emit_fire) begin
            out_pair_r  <= {work_r[1], work_r[0]};
            out_idx_r   <= emit_r;
            out_last_r  <= (emit_r == PAIR_IDX_W'(NUM_PAIRS - 1));
            work_r      <= work_r >> PAIR_W;
            emit_r      <= emit_r + 1'b1;
            if (emit_r == PAIR_IDX_W'(NUM_PAIRS - 1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.keystream_pair = out_pair_r;
  assign out_ch.pair_index     = out_idx_r;
  assign out_ch.last_pair      = out_last_r;

endmodule

@@ sv/cc20_checker.sv @@
// ---------------------------------------------------------------------------
// cc20_checker
// Port-level assertions for the ChaCha20 block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cc20_checker import cc20_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PAIR_W-1:0]     out_keystream_pair,
  input logic [PAIR_IDX_W-1:0] out_pair_index,
  input logic                  out_last_pair
);

  // An accepted counter keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // The last flag marks exactly the eighth pair.
  `ASSERT_NOW(a_last_flag, clk, rst_n, out_valid, out_last_pair == (out_pair_index == PAIR_IDX_W'(NUM_PAIRS - 1)))

  // While pairs remain after the next one, no new counter is taken.
  `ASSERT_NEXT(a_busy_mid_block, clk, rst_n, out_valid && out_ready && (out_pair_index < PAIR_IDX_W'(NUM_PAIRS - 2)), !in_ready)

  // Pairs of one block follow each other without gaps, in order.
  `ASSERT_NEXT(a_pair_sequence, clk, rst_n, out_valid && out_ready && !out_last_pair, out_valid && (out_pair_index == $past(out_pair_index) + 3'd1))

  // A stalled transaction holds its payload.
  `ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_keystream_pair) && $stable(out_pair_index))

endmodule

bind chacha20_ietf_block_top cc20_checker u_cc20_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_keystream_pair (out_ch.keystream_pair),
  .out_pair_index     (out_ch.pair_index),
  .out_last_pair      (out_ch.last_pair)
);
